[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the odometry integrator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define PTODO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle.
`define PTODO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ptodo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptodo_pkg
// Types, constants and helper functions of the planar odometry integrator.
// ----------------------------------------------------------------------------
package ptodo_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam logic [15:0] STEP_TIME_RESET = 16'd1638;

	// CORDIC datapath width (Q2.30 with headroom) and shift-add accumulator width.
	localparam int CW = 34;
	localparam int ACC_W = 52;
	localparam int RV_W = 38;
	localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;

	typedef struct packed {
		logic               action;
		logic signed [15:0] lin_vel_x;
		logic signed [15:0] lin_vel_y;
		logic signed [15:0] ang_rate_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        heading_angle;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_z;
		logic signed [15:0] echo_vel_x;
		logic signed [15:0] echo_rate_z;
	} out_t;

	typedef struct packed {
		logic en;
		logic clr;
		logic dbl;
		logic sub;
	} mac_cmd_t;

	localparam logic ACT_COMMAND = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Arctangent of 2^-k in binary-angle units (2^32 per turn).
	function automatic logic [29:0] atan_lut(input logic [4:0] k);
		logic [29:0] r;
		unique case (k)
			5'd0: r = 30'h20000000;
			5'd1: r = 30'h12E4051E;
			5'd2: r = 30'h09FB385B;
			5'd3: r = 30'h051111D4;
			5'd4: r = 30'h028B0D43;
			5'd5: r = 30'h0145D7E1;
			5'd6: r = 30'h00A2F61E;
			5'd7: r = 30'h00517C55;
			5'd8: r = 30'h0028BE53;
			5'd9: r = 30'h00145F2F;
			5'd10: r = 30'h000A2F98;
			5'd11: r = 30'h000517CC;
			5'd12: r = 30'h00028BE6;
			5'd13: r = 30'h000145F3;
			5'd14: r = 30'h0000A2FA;
			5'd15: r = 30'h0000517D;
			5'd16: r = 30'h000028BE;
			5'd17: r = 30'h0000145F;
			5'd18: r = 30'h00000A30;
			5'd19: r = 30'h00000518;
			5'd20: r = 30'h0000028C;
			5'd21: r = 30'h00000146;
			5'd22: r = 30'h000000A3;
			5'd23: r = 30'h00000051;
			5'd24: r = 30'h00000029;
			5'd25: r = 30'h00000014;
			5'd26: r = 30'h0000000A;
			5'd27: r = 30'h00000005;
			5'd28: r = 30'h00000003;
			5'd29: r = 30'h00000001;
			5'd30: r = 30'h00000001;
			5'd31: r = 30'h00000000;
		endcase
		return r;
	endfunction

	// Round a Q2.30 value to Q1.14 and clamp it to plus or minus one.
	function automatic logic signed [15:0] to_q14(input logic signed [CW-1:0] v);
		logic signed [CW:0] t;
		logic signed [CW-16:0] r;
		logic signed [15:0] q;
		t = {v[CW-1], v} + (CW+1)'(32768);
		r = t[CW:16];
		if (r > (CW-15)'(16384)) begin
			q = 16'sd16384;
		end else if (r < -(CW-15)'(16384)) begin
			q = -16'sd16384;
		end else begin
			q = r[15:0];
		end
		return q;
	endfunction

endpackage

[rtl/ptodo_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptodo_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface ptodo_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/ptodo_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptodo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ptodo_cordic import ptodo_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          angle,
	output logic                 done,
	output logic signed [CW-1:0] cos_val,
	output logic signed [CW-1:0] sin_val
);
	localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam logic [IW-1:0] LAST = IW'(STAGES - 1);

	logic                 run_q, done_q, flip_q;
	logic [IW-1:0]        it_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [31:0]          folded;
	logic                 fold;
	logic [4:0]           k;
	logic signed [CW-1:0] x_sh, y_sh, at;

	// Fold the angle into the quarter turns around zero; negate the result later.
	assign fold = angle[31] ^ angle[30];
	assign folded = fold ? (angle ^ 32'h8000_0000) : angle;
	assign k = 5'(it_q);
	assign x_sh = x_q >>> k;
	assign y_sh = y_q >>> k;
	assign at = $signed({{(CW-30){1'b0}}, atan_lut(k)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			it_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				it_q <= '0;
			end else if (run_q) begin
				if (it_q == LAST) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
				it_q <= it_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= INV_GAIN;
			y_q <= '0;
			z_q <= {{(CW-32){folded[31]}}, folded};
			flip_q <= fold;
		end else if (run_q) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;
endmodule

[rtl/ptodo_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptodo_mac
// Bit-serial shift-add accumulator: one multiplier bit per doubling step.
// ----------------------------------------------------------------------------
module ptodo_mac import ptodo_pkg::*; (
	input  logic                    clk,
	input  mac_cmd_t                cmd,
	input  logic signed [ACC_W-1:0] op,
	output logic signed [ACC_W-1:0] acc
);
	logic signed [ACC_W-1:0] acc_q, base;

	assign base = cmd.clr ? '0 : (cmd.dbl ? (acc_q <<< 1) : acc_q);

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			acc_q <= cmd.sub ? (base - op) : (base + op);
		end
	end

	assign acc = acc_q;
endmodule

[rtl/planar_odometry_integrator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_odometry_integrator
// Planar dead-reckoning integrator with CORDIC yaw quaternion output.
// ----------------------------------------------------------------------------
// Usage: items arrive on din. An item with action 0 stores the body-frame
// velocity command and gives no result. An item with action 1
// is a tick: the stored velocity is rotated by the current heading, scaled by
// step_time and added to the saturating position, the scaled yaw rate is added
// to the wrapping heading, and one pose item leaves on dout.
// The cfg channel writes step_time (Q0.16 seconds); it is always ready.
// A tick runs a CORDIC pass on the old heading, rotates and scales each
// axis in the single bit-serial accumulator, scales the yaw rate there,
// and runs a second pass of the one-step-per-cycle CORDIC on half the new
// heading. No new item is taken until the pose of the tick has been
// loaded into the result register.
// Reset clears the stored command, position and heading and sets step_time to
// 1/40 second. The result register holds a pose while dout.ready is low; the
// next tick may be accepted and worked on meanwhile, and it waits in its last
// step until the register is free.
// ----------------------------------------------------------------------------
module planar_odometry_integrator import ptodo_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ptodo_chan_if.sink        din,
	ptodo_chan_if.source      dout,
	ptodo_chan_if.sink        cfg
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_COR1 = 4'd1;
	localparam logic [3:0] S_ROTX = 4'd2;
	localparam logic [3:0] S_ADVX = 4'd3;
	localparam logic [3:0] S_MULX = 4'd4;
	localparam logic [3:0] S_UPDX = 4'd5;
	localparam logic [3:0] S_ROTY = 4'd6;
	localparam logic [3:0] S_ADVY = 4'd7;
	localparam logic [3:0] S_MULY = 4'd8;
	localparam logic [3:0] S_UPDY = 4'd9;
	localparam logic [3:0] S_HEAD = 4'd10;
	localparam logic [3:0] S_HUPD = 4'd11;
	localparam logic [3:0] S_COR2 = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0]  state_q;
	logic [4:0]  cnt_q;
	logic [15:0] step_q;

	// Stored command and integrator state.
	logic signed [15:0] vx_q, vy_q, rate_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [31:0]        head_q;
	logic signed [RV_W-1:0] rv_q;

	out_t out_q;
	logic out_v_q;

	logic                    cor_start, cor_done;
	logic [31:0]             cor_angle, head_next;
	logic signed [CW-1:0]    cos_v, sin_v;
	mac_cmd_t                mac_cmd;
	logic signed [ACC_W-1:0] mac_op, acc;
	logic signed [ACC_W-1:0] c_ext, s_ext, rv_ext, rate_ext, rnd_acc;

	logic [3:0] rot_bit, mul_bit;
	logic       rot_msb, phase, rot_last, mul_last, in_acc, out_free;
	logic signed [ACC_W-1:0] d_sum;
	logic signed [23:0]      d_step;
	logic signed [32:0]      pos_sum;
	logic signed [31:0]      pos_sat, pos_cur;

	assign din.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign in_acc = din.valid && din.ready;
	assign out_free = !out_v_q || dout.ready;

	// During rotation each velocity bit takes a cosine term, then a sine term.
	assign rot_bit = ~cnt_q[4:1];
	assign rot_msb = (cnt_q[4:1] == 4'd0);
	assign phase = cnt_q[0];
	assign rot_last = (cnt_q == 5'd31);
	assign mul_bit = ~cnt_q[3:0];
	assign mul_last = (cnt_q[3:0] == 4'hF);

	assign c_ext = {{(ACC_W-CW){cos_v[CW-1]}}, cos_v};
	assign s_ext = {{(ACC_W-CW){sin_v[CW-1]}}, sin_v};
	assign rv_ext = {{(ACC_W-RV_W){rv_q[RV_W-1]}}, rv_q};
	assign rate_ext = {{(ACC_W-16){rate_q[15]}}, rate_q};

	always_comb begin
		mac_cmd = '0;
		mac_op = '0;
		unique case (state_q)
			S_ROTX: begin
				mac_cmd.en = 1'b1;
				if (!phase) begin
					mac_cmd.clr = (cnt_q == 5'd0);
					mac_cmd.dbl = 1'b1;
					mac_cmd.sub = rot_msb;
					mac_op = vx_q[rot_bit] ? c_ext : '0;
				end else begin
					mac_cmd.sub = !rot_msb;
					mac_op = vy_q[rot_bit] ? s_ext : '0;
				end
			end
			S_ROTY: begin
				mac_cmd.en = 1'b1;
				if (!phase) begin
					mac_cmd.clr = (cnt_q == 5'd0);
					mac_cmd.dbl = 1'b1;
					mac_cmd.sub = rot_msb;
					mac_op = vy_q[rot_bit] ? c_ext : '0;
				end else begin
					mac_cmd.sub = rot_msb;
					mac_op = vx_q[rot_bit] ? s_ext : '0;
				end
			end
			S_MULX, S_MULY: begin
				mac_cmd.en = 1'b1;
				mac_cmd.clr = (cnt_q[3:0] == 4'd0);
				mac_cmd.dbl = 1'b1;
				mac_op = step_q[mul_bit] ? rv_ext : '0;
			end
			S_HEAD: begin
				mac_cmd.en = 1'b1;
				mac_cmd.clr = (cnt_q[3:0] == 4'd0);
				mac_cmd.dbl = 1'b1;
				mac_op = step_q[mul_bit] ? rate_ext : '0;
			end
			default: begin
				mac_cmd = '0;
				mac_op = '0;
			end
		endcase
	end

	ptodo_mac u_mac (
		.clk (clk),
		.cmd (mac_cmd),
		.op  (mac_op),
		.acc (acc)
	);

	// The first pass uses the heading before the tick, the second half the new one.
	assign head_next = head_q + acc[31:0];
	assign cor_start = (in_acc && din.data.action == ACT_TICK) || (state_q == S_HUPD);
	assign cor_angle = (state_q == S_IDLE) ? head_q : {1'b0, head_next[31:1]};

	ptodo_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (cor_angle),
		.done    (cor_done),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	// Rounding of the rotated velocity, then of the scaled position step.
	assign rnd_acc = acc + ACC_W'(8192);
	assign d_sum = acc + ACC_W'(134217728);
	assign d_step = d_sum[51:28];
	assign pos_cur = (state_q == S_UPDX) ? pos_x_q : pos_y_q;
	assign pos_sum = {pos_cur[31], pos_cur} + {{9{d_step[23]}}, d_step};

	always_comb begin
		if (pos_sum[32] != pos_sum[31]) begin
			pos_sat = pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			pos_sat = pos_sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			step_q <= STEP_TIME_RESET;
			vx_q <= '0;
			vy_q <= '0;
			rate_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				step_q <= cfg.data;
			end
			if (state_q == S_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (dout.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (din.data.action == ACT_COMMAND) begin
							vx_q <= din.data.lin_vel_x;
							vy_q <= din.data.lin_vel_y;
							rate_q <= din.data.ang_rate_z;
						end else begin
							state_q <= S_COR1;
						end
					end
				end
				S_COR1: begin
					cnt_q <= '0;
					if (cor_done) begin
						state_q <= S_ROTX;
					end
				end
				S_ROTX, S_ROTY: begin
					cnt_q <= cnt_q + 1'b1;
					if (rot_last) begin
						state_q <= (state_q == S_ROTX) ? S_ADVX : S_ADVY;
					end
				end
				S_ADVX, S_ADVY: begin
					cnt_q <= '0;
					state_q <= (state_q == S_ADVX) ? S_MULX : S_MULY;
				end
				S_MULX, S_MULY: begin
					cnt_q <= cnt_q + 1'b1;
					if (mul_last) begin
						state_q <= (state_q == S_MULX) ? S_UPDX : S_UPDY;
					end
				end
				S_UPDX: begin
					pos_x_q <= pos_sat;
					cnt_q <= '0;
					state_q <= S_ROTY;
				end
				S_UPDY: begin
					pos_y_q <= pos_sat;
					cnt_q <= '0;
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					cnt_q <= cnt_q + 1'b1;
					if (mul_last) begin
						state_q <= S_HUPD;
					end
				end
				S_HUPD: begin
					head_q <= head_next;
					state_q <= S_COR2;
				end
				S_COR2: begin
					if (cor_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (state_q == S_ADVX || state_q == S_ADVY) begin
			rv_q <= rnd_acc[RV_W+13:14];
		end
		if (state_q == S_DONE && out_free) begin
			out_q.pos_x <= pos_x_q;
			out_q.pos_y <= pos_y_q;
			out_q.heading_angle <= head_q;
			out_q.quat_w <= to_q14(cos_v);
			out_q.quat_z <= to_q14(sin_v);
			out_q.echo_vel_x <= vx_q;
			out_q.echo_rate_z <= rate_q;
		end
	end

	assign dout.valid = out_v_q;
	assign dout.data = out_q;
endmodule

[rtl/ptodo_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptodo_checker
// Port-level checks of the odometry integrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptodo_checker import ptodo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_action,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);
	// A pending result stays offered until taken.
	`PTODO_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	// A stalled result keeps its value.
	`PTODO_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data), "result changed while stalled")
	// A velocity command never produces a result.
	`PTODO_ASSERT_NEXT(a_cmd_silent, clk, arst_n, in_valid && in_ready && !in_action && !out_valid, !out_valid, "result after a command item")
	// Quaternion parts are clamped to plus or minus one in Q1.14.
	`PTODO_ASSERT_NOW(a_quat_range, clk, arst_n, out_valid, out_data.quat_w <= 16'sd16384 && out_data.quat_w >= -16'sd16384 && out_data.quat_z <= 16'sd16384 && out_data.quat_z >= -16'sd16384, "quaternion out of range")
endmodule

bind planar_odometry_integrator ptodo_checker u_ptodo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.in_action (din.data.action),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_data  (dout.data)
);

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the planar odometry integrator. A driver feeds
// command, tick and step_time items from a queue. A predictor integrates each
// tick the way the block should and queues the expected pose. A monitor checks
// every pose field against that queue while both sides idle and stall.
// ----------------------------------------------------------------------------
module tb;
	import ptodo_pkg::*;

	localparam int STAGES = 16;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE = 300;

	// Arctangent of 2^-k in binary-angle units, for the stages used here.
	localparam longint ATAN_BAM [0:15] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
	};

	typedef enum logic [1:0] {OP_ITEM, OP_STEP, OP_DRAIN} op_kind_e;

	typedef struct {
		op_kind_e    kind;
		in_t         item;
		logic [15:0] step;
	} op_t;

	logic clk;
	logic arst_n;

	ptodo_chan_if #(.T(in_t))         din_if ();
	ptodo_chan_if #(.T(out_t))        dout_if ();
	ptodo_chan_if #(.T(logic [15:0])) cfg_if ();

	planar_odometry_integrator #(.CORDIC_STAGES(STAGES)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if.sink),
		.dout   (dout_if.source),
		.cfg    (cfg_if.sink)
	);

	// Pending stimulus and the poses the block should return, oldest first.
	op_t  op_q[$];
	out_t pose_q[$];

	// Predictor state: the block's register and integrator state as we see it.
	logic [15:0]        step_time;
	logic signed [15:0] cmd_vx, cmd_vy, cmd_rate;
	logic signed [31:0] acc_x, acc_y;
	logic [31:0]        acc_heading;

	int errors = 0;
	int n_cmds = 0, n_ticks = 0, n_steps = 0, n_poses = 0, n_sat = 0;
	int idle_cycles = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Rotation-mode CORDIC on a binary angle, giving cos and sin in Q2.30.
	// Angles outside the right half plane are turned by a half turn first and
	// the result negated afterwards.
	function automatic void rotate_angle(input logic [31:0] ang,
			output longint c, output longint s);
		logic [31:0] a;
		logic        flip;
		longint      x, y, z, nx;
		a = ang;
		flip = 1'b0;
		if (((a + 32'h40000000) & 32'h80000000) != 0) begin
			a = a - 32'h80000000;
			flip = 1'b1;
		end
		z = longint'($signed(a));
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ATAN_BAM[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ATAN_BAM[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// Adds one scaled, rounded position step to an axis and saturates.
	function automatic logic signed [31:0] advance_axis(input logic signed [31:0] pos,
			input longint rot, input logic [15:0] st);
		longint rv, d, p;
		rv = (rot + 64'sd8192) >>> 14;
		d = (rv * longint'({48'd0, st}) + (64'sd1 <<< 27)) >>> 28;
		p = longint'(pos) + d;
		if (p > 64'sd2147483647)
			p = 64'sd2147483647;
		if (p < -64'sd2147483648)
			p = -64'sd2147483648;
		return p[31:0];
	endfunction

	function automatic logic signed [15:0] round_q14(input longint v);
		longint r;
		r = (v + 64'sd32768) >>> 16;
		if (r > 64'sd16384)
			r = 64'sd16384;
		if (r < -64'sd16384)
			r = -64'sd16384;
		return r[15:0];
	endfunction

	// Applies one accepted input item to the predicted state and queues the
	// expected pose when the item is a tick.
	task automatic integrate_item(input in_t it);
		longint c, s;
		longint vx, vy;
		out_t   pose;
		logic signed [31:0] nx, ny;
		if (it.action == ACT_COMMAND) begin
			cmd_vx = it.lin_vel_x;
			cmd_vy = it.lin_vel_y;
			cmd_rate = it.ang_rate_z;
			n_cmds++;
		end else begin
			vx = longint'(cmd_vx);
			vy = longint'(cmd_vy);
			rotate_angle(acc_heading, c, s);
			nx = advance_axis(acc_x, vx * c - vy * s, step_time);
			ny = advance_axis(acc_y, vy * c + vx * s, step_time);
			if (nx == 32'sh7fffffff || nx == 32'sh80000000 ||
					ny == 32'sh7fffffff || ny == 32'sh80000000)
				n_sat++;
			acc_x = nx;
			acc_y = ny;
			acc_heading = acc_heading +
				32'(longint'(cmd_rate) * longint'({48'd0, step_time}));
			rotate_angle({1'b0, acc_heading[31:1]}, c, s);
			pose.pos_x = acc_x;
			pose.pos_y = acc_y;
			pose.heading_angle = acc_heading;
			pose.quat_w = round_q14(c);
			pose.quat_z = round_q14(s);
			pose.echo_vel_x = cmd_vx;
			pose.echo_rate_z = cmd_rate;
			pose_q.push_back(pose);
			n_ticks++;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	function automatic void push_item(input logic act, input logic [15:0] vx,
			input logic [15:0] vy, input logic [15:0] rate);
		op_t op;
		op.kind = OP_ITEM;
		op.item.action = act;
		op.item.lin_vel_x = vx;
		op.item.lin_vel_y = vy;
		op.item.ang_rate_z = rate;
		op.step = '0;
		op_q.push_back(op);
	endfunction

	// A step_time write is always fenced by a drain so the block is idle.
	function automatic void push_step(input logic [15:0] st);
		op_t op;
		op.kind = OP_DRAIN;
		op.item = '0;
		op.step = '0;
		op_q.push_back(op);
		op.kind = OP_STEP;
		op.step = st;
		op_q.push_back(op);
	endfunction

	function automatic void push_random_item();
		if ($urandom_range(0, 9) < 3)
			push_item(ACT_COMMAND, 16'($urandom), 16'($urandom), 16'($urandom));
		else
			push_item(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	// ------------------------------------------------------------------------
	// Driver. Items go out in bursts of random length separated by random
	// gaps; about half the bursts are followed by no gap at all. A drain entry
	// holds the sender until every expected pose has come back and then lets
	// the block settle before the next entry, which is how register writes are
	// kept to idle periods.
	// ------------------------------------------------------------------------
	int   burst_left = 0;
	int   gap_left = 0;
	int   hold_left = 0;
	logic draining = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		op_t  op;
		logic nxt_valid, nxt_cfg_valid;
		if (!arst_n) begin
			din_if.valid <= 1'b0;
			din_if.data <= '0;
			cfg_if.valid <= 1'b0;
			cfg_if.data <= '0;
		end else if ((din_if.valid && !din_if.ready) || (cfg_if.valid && !cfg_if.ready)) begin
			// The current item has not been taken yet; hold it.
		end else begin
			nxt_valid = 1'b0;
			nxt_cfg_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (draining) begin
				if (pose_q.size() == 0 && !dout_if.valid) begin
					draining = 1'b0;
					hold_left = SETTLE;
				end
			end else if (op_q.size() > 0) begin
				op = op_q.pop_front();
				case (op.kind)
					OP_ITEM: begin
						din_if.data <= op.item;
						nxt_valid = 1'b1;
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(0, 12);
							gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
						end
					end
					OP_STEP: begin
						cfg_if.data <= op.step;
						nxt_cfg_valid = 1'b1;
					end
					default: begin
						draining = 1'b1;
					end
				endcase
			end
			din_if.valid <= nxt_valid;
			cfg_if.valid <= nxt_cfg_valid;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver. The stall pattern rotates through always ready, random ready
	// and occasional long stalls.
	// ------------------------------------------------------------------------
	int cyc = 0;
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
		end else begin
			cyc++;
			case ((cyc / 700) % 3)
				0: begin
					dout_if.ready <= 1'b1;
				end
				1: begin
					dout_if.ready <= ($urandom_range(0, 1) == 1);
				end
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						dout_if.ready <= 1'b0;
					end else begin
						if ($urandom_range(0, 9) == 0)
							stall_left = $urandom_range(1, 25);
						dout_if.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Input items are predicted as they are accepted; each pose is
	// checked field by field against the oldest expectation. The watchdog
	// ends the run when nothing at all is accepted for too long.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_t want;
		out_t got;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				step_time = cfg_if.data;
				n_steps++;
			end
			if (din_if.valid && din_if.ready)
				integrate_item(din_if.data);
			if (dout_if.valid && dout_if.ready) begin
				got = dout_if.data;
				n_poses++;
				if (pose_q.size() == 0) begin
					errors++;
					$display("[%0t] pose returned with none expected", $realtime);
				end else begin
					want = pose_q.pop_front();
					if (got.pos_x !== want.pos_x)
						report_mismatch("pos_x", got.pos_x, want.pos_x);
					if (got.pos_y !== want.pos_y)
						report_mismatch("pos_y", got.pos_y, want.pos_y);
					if (got.heading_angle !== want.heading_angle)
						report_mismatch("heading_angle", got.heading_angle,
							want.heading_angle);
					if (got.quat_w !== want.quat_w)
						report_mismatch("quat_w", got.quat_w, want.quat_w);
					if (got.quat_z !== want.quat_z)
						report_mismatch("quat_z", got.quat_z, want.quat_z);
					if (got.echo_vel_x !== want.echo_vel_x)
						report_mismatch("echo_vel_x", got.echo_vel_x, want.echo_vel_x);
					if (got.echo_rate_z !== want.echo_rate_z)
						report_mismatch("echo_rate_z", got.echo_rate_z, want.echo_rate_z);
				end
			end
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: %0d cycles without any accepted item", IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus plan and end of run.
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		step_time = STEP_TIME_RESET;
		cmd_vx = '0;
		cmd_vy = '0;
		cmd_rate = '0;
		acc_x = '0;
		acc_y = '0;
		acc_heading = '0;

		// Directed part at the reset step time: a tick with nothing stored,
		// then the field extremes in both signs and a return to standstill.
		push_item(ACT_TICK, 16'h7fff, 16'h8000, 16'h7fff);
		push_item(ACT_COMMAND, 16'h7fff, 16'h8000, 16'h7fff);
		push_item(ACT_TICK, '0, '0, '0);
		push_item(ACT_TICK, '0, '0, '0);
		push_item(ACT_COMMAND, 16'h8000, 16'h7fff, 16'h8000);
		push_item(ACT_TICK, 16'hffff, 16'hffff, 16'hffff);
		push_item(ACT_COMMAND, '0, '0, '0);
		push_item(ACT_TICK, '0, '0, '0);

		// Largest step: the heading moves nearly a half turn per tick and wraps.
		push_step(16'hffff);
		push_item(ACT_COMMAND, 16'h0001, 16'hffff, 16'h7fff);
		push_item(ACT_TICK, '0, '0, '0);
		push_item(ACT_TICK, '0, '0, '0);
		push_item(ACT_TICK, '0, '0, '0);
		push_item(ACT_COMMAND, 16'h8000, 16'h8000, 16'h8000);
		push_item(ACT_TICK, '0, '0, '0);
		push_item(ACT_TICK, '0, '0, '0);

		// Zero step time still yields a pose, with position and heading held.
		push_step(16'h0000);
		push_item(ACT_COMMAND, 16'h1234, 16'hedcb, 16'h4321);
		push_item(ACT_TICK, '0, '0, '0);
		push_item(ACT_TICK, '0, '0, '0);

		// Smallest step.
		push_step(16'h0001);
		push_item(ACT_COMMAND, 16'h7fff, 16'h7fff, 16'h7fff);
		push_item(ACT_TICK, '0, '0, '0);

		// A long stretch at the fastest command and the largest step carries
		// the position far from the origin, then the direction reverses.
		push_step(16'hffff);
		push_item(ACT_COMMAND, 16'h7fff, 16'h8000, 16'h0000);
		for (int i = 0; i < 200; i++)
			push_item(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		push_item(ACT_COMMAND, 16'h8000, 16'h7fff, 16'h0400);
		for (int i = 0; i < 20; i++)
			push_item(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom));

		// Random part in phases of random step time, extremes included.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: push_step(16'd1638);
				1: push_step(16'hffff);
				2: push_step(16'h0001);
				default: push_step(16'($urandom_range(1, 65535)));
			endcase
			for (int i = 0; i < 50; i++)
				push_random_item();
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (op_q.size() == 0 && !draining);
		@(posedge clk);
		while (din_if.valid || cfg_if.valid || pose_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (pose_q.size() != 0) begin
			errors++;
			$display("%0d expected poses never arrived", pose_q.size());
		end
		$display("Covered %0d commands, %0d ticks, %0d step_time writes.",
			n_cmds, n_ticks, n_steps);
		$display("Checked %0d poses, %0d of them at a saturated position; %0d errors.",
			n_poses, n_sat, errors);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
